/* hdl/rcdt_pkg.sv */
// Shared types and constants for the render clock drift tracker.
// Used by the controller, the datapath, the top level and the checker.
package rcdt_pkg;

    // shared multiplier: 40 x 16 bits, registered product
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int Q8_SHIFT   = 8;
    localparam int FRAC_SHIFT = 16;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SRC_W     = 48;
    localparam int DELTA_W   = 32;
    localparam int SPEED_W   = 16;
    localparam int FRAC_W    = 16;
    localparam int ACT_W     = 2;

    localparam logic [SPEED_W-1:0] SPEED_ONE = 16'd256;

    localparam logic [CFG_W-1:0]  BASE_DELAY_RST  = 32'd6553600;
    localparam logic [CFG_W-1:0]  DRIFT_LIMIT_RST = 32'd32768000;
    localparam logic [FRAC_W-1:0] CORR_FRAC_RST   = 16'd6554;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_FRAC   = 2'd2;

    localparam logic [ACT_W-1:0] ACT_INIT    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CORRECT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SNAP    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DELAY,
        ST_IDEAL,
        ST_INIT,
        ST_LIMIT,
        ST_ADVANCE,
        ST_DRIFT,
        ST_DECIDE,
        ST_CORR,
        ST_CLAMP,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_DELAY,
        MUL_LIMIT,
        MUL_ADV,
        MUL_CORR
    } t_mul_sel;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_IDEAL,
        OP_INIT,
        OP_LIMIT,
        OP_ADVANCE,
        OP_DRIFT,
        OP_SNAP,
        OP_CORR,
        OP_CLAMP,
        OP_COMMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op   op;
        t_mul_sel mul_sel;
    } t_cmd;

    typedef struct packed {
        logic init_hit;
        logic snap_hit;
    } t_sts;

endpackage

/* hdl/rcdt_ctrl.sv */
// Sequencer for the drift tracker: walks one word through the datapath steps.
// Depends on rcdt_pkg; drives rcdt_datapath through a command struct.
module rcdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rcdt_pkg::t_sts i_sts,
    output rcdt_pkg::t_cmd o_cmd
);

    rcdt_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcdt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = rcdt_pkg::OP_NONE;
        o_cmd.mul_sel = rcdt_pkg::MUL_DELAY;
        commit        = 1'b0;
        case (r_state)
            rcdt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = rcdt_pkg::OP_LOAD_IN;
                    n_state  = rcdt_pkg::ST_MUL_DELAY;
                end
            end
            rcdt_pkg::ST_MUL_DELAY: begin
                o_cmd.mul_sel = rcdt_pkg::MUL_DELAY;
                n_state       = rcdt_pkg::ST_IDEAL;
            end
            rcdt_pkg::ST_IDEAL: begin
                o_cmd.op      = rcdt_pkg::OP_IDEAL;
                o_cmd.mul_sel = rcdt_pkg::MUL_LIMIT;
                n_state       = i_sts.init_hit ? rcdt_pkg::ST_INIT : rcdt_pkg::ST_LIMIT;
            end
            rcdt_pkg::ST_INIT: begin
                o_cmd.op = rcdt_pkg::OP_INIT;
                n_state  = rcdt_pkg::ST_DONE;
            end
            rcdt_pkg::ST_LIMIT: begin
                o_cmd.op      = rcdt_pkg::OP_LIMIT;
                o_cmd.mul_sel = rcdt_pkg::MUL_ADV;
                n_state       = rcdt_pkg::ST_ADVANCE;
            end
            rcdt_pkg::ST_ADVANCE: begin
                o_cmd.op = rcdt_pkg::OP_ADVANCE;
                n_state  = rcdt_pkg::ST_DRIFT;
            end
            rcdt_pkg::ST_DRIFT: begin
                o_cmd.op = rcdt_pkg::OP_DRIFT;
                n_state  = rcdt_pkg::ST_DECIDE;
            end
            rcdt_pkg::ST_DECIDE: begin
                // start the correction product whether or not it is needed
                o_cmd.mul_sel = rcdt_pkg::MUL_CORR;
                if (i_sts.snap_hit) begin
                    o_cmd.op = rcdt_pkg::OP_SNAP;
                    n_state  = rcdt_pkg::ST_CLAMP;
                end else begin
                    n_state  = rcdt_pkg::ST_CORR;
                end
            end
            rcdt_pkg::ST_CORR: begin
                o_cmd.op = rcdt_pkg::OP_CORR;
                n_state  = rcdt_pkg::ST_CLAMP;
            end
            rcdt_pkg::ST_CLAMP: begin
                o_cmd.op = rcdt_pkg::OP_CLAMP;
                n_state  = rcdt_pkg::ST_DONE;
            end
            rcdt_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = rcdt_pkg::OP_COMMIT;
                    commit   = 1'b1;
                    n_state  = rcdt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rcdt_pkg::ST_IDLE;
            end
        endcase
        n_out_valid = commit | (r_out_valid & ~i_out_ready);
    end

    assign o_in_ready  = (r_state == rcdt_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* hdl/rcdt_datapath.sv */
// Datapath for the drift tracker: configuration, follower state, shared
// multiplier and output register. Depends on rcdt_pkg; steered by rcdt_ctrl.
module rcdt_datapath #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rcdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcdt_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [rcdt_pkg::DELTA_W-1:0]     i_frame_delta,
    input  logic [rcdt_pkg::SRC_W-1:0]       i_source_time,
    input  logic [rcdt_pkg::SPEED_W-1:0]     i_speed_factor,
    input  rcdt_pkg::t_cmd                   i_cmd,
    output rcdt_pkg::t_sts                   o_sts,
    output logic [rcdt_pkg::SRC_W-1:0]       o_follower_time,
    output logic [rcdt_pkg::ACT_W-1:0]       o_action,
    output logic                             o_clamped
);

    localparam logic [TIME_WIDTH-1:0] TMAX = '1;

    function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [63:0] v);
        return (v > 64'(TMAX)) ? TMAX : v[TIME_WIDTH-1:0];
    endfunction

    logic [rcdt_pkg::CFG_W-1:0]     r_base_delay;
    logic [rcdt_pkg::CFG_W-1:0]     r_drift_limit;
    logic [rcdt_pkg::FRAC_W-1:0]    r_corr_frac;
    logic [TIME_WIDTH-1:0]          r_fol;

    logic [rcdt_pkg::DELTA_W-1:0]   r_delta;
    logic [TIME_WIDTH-1:0]          r_src;
    logic [rcdt_pkg::SPEED_W-1:0]   r_speed;
    logic [rcdt_pkg::SPEED_W-1:0]   r_eff;
    logic [rcdt_pkg::PROD_W-1:0]    r_prod;
    logic [TIME_WIDTH-1:0]          r_ideal;
    logic [TIME_WIDTH-1:0]          r_limit;
    logic [TIME_WIDTH-1:0]          r_work;
    logic [TIME_WIDTH-1:0]          r_drift;
    logic                           r_up;
    logic [rcdt_pkg::ACT_W-1:0]     r_action;
    logic                           r_clamped;
    logic [rcdt_pkg::SRC_W-1:0]     r_out_time;
    logic [rcdt_pkg::ACT_W-1:0]     r_out_action;
    logic                           r_out_clamped;

    logic [rcdt_pkg::MUL_A_W-1:0]   mul_a;
    logic [rcdt_pkg::MUL_B_W-1:0]   mul_b;
    logic [rcdt_pkg::PROD_W-1:0]    mul_p;
    logic [TIME_WIDTH-1:0]          scaled;
    logic [TIME_WIDTH-1:0]          ideal;
    logic [TIME_WIDTH:0]            adv_sum;
    logic [TIME_WIDTH-1:0]          corr;
    logic [63:0]                    drift64;
    logic [63:0]                    work64;
    logic [63:0]                    corr64;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay  <= rcdt_pkg::BASE_DELAY_RST;
            r_drift_limit <= rcdt_pkg::DRIFT_LIMIT_RST;
            r_corr_frac   <= rcdt_pkg::CORR_FRAC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rcdt_pkg::REG_BASE_DELAY:  r_base_delay  <= i_cfg_data;
                rcdt_pkg::REG_DRIFT_LIMIT: r_drift_limit <= i_cfg_data;
                rcdt_pkg::REG_CORR_FRAC:   r_corr_frac   <= i_cfg_data[rcdt_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    assign drift64 = 64'(r_drift);
    always_comb begin
        case (i_cmd.mul_sel)
            rcdt_pkg::MUL_DELAY: begin
                mul_a = rcdt_pkg::MUL_A_W'(r_base_delay);
                mul_b = r_eff;
            end
            rcdt_pkg::MUL_LIMIT: begin
                mul_a = rcdt_pkg::MUL_A_W'(r_drift_limit);
                mul_b = r_eff;
            end
            rcdt_pkg::MUL_ADV: begin
                mul_a = rcdt_pkg::MUL_A_W'(r_delta);
                mul_b = r_speed;
            end
            rcdt_pkg::MUL_CORR: begin
                // drift is at most the limit when this product is used, so 40 bits hold it
                mul_a = drift64[rcdt_pkg::MUL_A_W-1:0];
                mul_b = r_corr_frac;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign scaled  = sat_time(64'(r_prod >> rcdt_pkg::Q8_SHIFT));
    assign ideal   = (r_src > scaled) ? (r_src - scaled) : '0;
    assign adv_sum = {1'b0, r_fol} + {1'b0, scaled};
    assign corr64  = 64'(r_prod >> rcdt_pkg::FRAC_SHIFT);
    assign corr    = corr64[TIME_WIDTH-1:0];
    assign work64  = 64'(r_work);

    assign o_sts.init_hit = (r_fol == '0) && (r_src != '0);
    assign o_sts.snap_hit = (r_drift > r_limit);

    // follower state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fol <= '0;
        end else if (i_cmd.op == rcdt_pkg::OP_COMMIT) begin
            r_fol <= r_work;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (i_cmd.op)
            rcdt_pkg::OP_LOAD_IN: begin
                r_delta <= i_frame_delta;
                r_src   <= sat_time(64'(i_source_time));
                r_speed <= i_speed_factor;
                r_eff   <= (i_speed_factor < rcdt_pkg::SPEED_ONE) ?
                           rcdt_pkg::SPEED_ONE : i_speed_factor;
            end
            rcdt_pkg::OP_IDEAL: begin
                r_ideal <= ideal;
            end
            rcdt_pkg::OP_INIT: begin
                r_work    <= r_ideal;
                r_action  <= rcdt_pkg::ACT_INIT;
                r_clamped <= 1'b0;
            end
            rcdt_pkg::OP_LIMIT: begin
                r_limit <= scaled;
            end
            rcdt_pkg::OP_ADVANCE: begin
                r_work <= adv_sum[TIME_WIDTH] ? TMAX : adv_sum[TIME_WIDTH-1:0];
            end
            rcdt_pkg::OP_DRIFT: begin
                r_up    <= (r_ideal >= r_work);
                r_drift <= (r_ideal >= r_work) ? (r_ideal - r_work) : (r_work - r_ideal);
            end
            rcdt_pkg::OP_SNAP: begin
                r_work   <= r_ideal;
                r_action <= rcdt_pkg::ACT_SNAP;
            end
            rcdt_pkg::OP_CORR: begin
                r_work   <= r_up ? (r_work + corr) : (r_work - corr);
                r_action <= rcdt_pkg::ACT_CORRECT;
            end
            rcdt_pkg::OP_CLAMP: begin
                if (r_work > r_src) begin
                    r_work    <= r_src;
                    r_clamped <= 1'b1;
                end else begin
                    r_clamped <= 1'b0;
                end
            end
            rcdt_pkg::OP_COMMIT: begin
                r_out_time    <= work64[rcdt_pkg::SRC_W-1:0];
                r_out_action  <= r_action;
                r_out_clamped <= r_clamped;
            end
            default: ;
        endcase
    end

    assign o_follower_time = r_out_time;
    assign o_action        = r_out_action;
    assign o_clamped       = r_out_clamped;

endmodule

/* hdl/render_clock_drift_tracker_core.sv */
// Render clock drift tracker, top level: controller plus datapath.
// Depends on rcdt_pkg, rcdt_ctrl and rcdt_datapath.
//
// One frame word in gives one result word out. A word is taken only while the
// sequencer is idle, and all its products go through a single shared 40x16
// multiplier with a registered product. A new word waits for the whole run
// of the last: delay product, ideal, limit, advance, drift, decide, correction,
// clamp, done (a snap skips correction; initialisation runs ideal, init, done),
// with done held while a previous result still sits in the output register.
// Results sit in an output register, so the next frame is accepted while the
// last result waits. No clearing pass follows reset; configuration writes
// take effect at the next clock edge and belong between frames.
module render_clock_drift_tracker_core #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcdt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rcdt_pkg::DELTA_W-1:0]   i_frame_delta,
    input  logic [rcdt_pkg::SRC_W-1:0]     i_source_time,
    input  logic [rcdt_pkg::SPEED_W-1:0]   i_speed_factor,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rcdt_pkg::SRC_W-1:0]     o_follower_time,
    output logic [rcdt_pkg::ACT_W-1:0]     o_action,
    output logic                           o_clamped
);

    rcdt_pkg::t_cmd cmd;
    rcdt_pkg::t_sts sts;

    rcdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rcdt_datapath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_frame_delta   (i_frame_delta),
        .i_source_time   (i_source_time),
        .i_speed_factor  (i_speed_factor),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_follower_time (o_follower_time),
        .o_action        (o_action),
        .o_clamped       (o_clamped)
    );

endmodule

/* hdl/rcdt_checker.sv */
// Port-level checks for the drift tracker, bound onto the top level.
// Depends on rcdt_pkg and render_clock_drift_tracker_core.
module rcdt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [rcdt_pkg::SRC_W-1:0]     o_follower_time,
    input logic [rcdt_pkg::ACT_W-1:0]     o_action,
    input logic                           o_clamped
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] r_pend;

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = o_out_valid & i_out_ready;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(in_acc) - 3'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_follower_time)
            && $stable(o_action) && $stable(o_clamped))
        else $error("stalled result word changed");

    a_init_unclamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == rcdt_pkg::ACT_INIT) |-> !o_clamped)
        else $error("initialisation result reported a clamp");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("ready held high straight after an accepted word");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend <= 3'd2) && (!o_out_valid || (r_pend != 3'd0)))
        else $error("result words out of step with accepted words");

endmodule

bind render_clock_drift_tracker_core rcdt_checker u_rcdt_checker (.*);

/* dv/tb_top.sv */
// Self-checking bench for render_clock_drift_tracker_core: frame words in, result words out.
// Holds its own follower predictor and register copies; depends on rcdt_pkg and the core.
module tb_top;

    localparam logic [63:0] TIME_MAX = 64'h0000_FFFF_FFFF_FFFF;
    localparam int SESSION_PHASES = 8;
    localparam int FRAMES_PER_PHASE = 175;

    typedef struct packed {
        logic [rcdt_pkg::DELTA_W-1:0] delta;
        logic [rcdt_pkg::SRC_W-1:0]   src;
        logic [rcdt_pkg::SPEED_W-1:0] speed;
    } t_frame_word;

    typedef struct {
        logic [rcdt_pkg::SRC_W-1:0] follower_time;
        logic [rcdt_pkg::ACT_W-1:0] action;
        logic                       clamped;
    } t_frame_result;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_we = 1'b0;
    logic [rcdt_pkg::CFG_IDX_W-1:0] cfg_index = rcdt_pkg::REG_BASE_DELAY;
    logic [rcdt_pkg::CFG_W-1:0]     cfg_data = '0;

    logic                         in_valid = 1'b0;
    logic [rcdt_pkg::DELTA_W-1:0] in_delta = '0;
    logic [rcdt_pkg::SRC_W-1:0]   in_src = '0;
    logic [rcdt_pkg::SPEED_W-1:0] in_speed = '0;
    logic                         out_ready = 1'b0;

    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [rcdt_pkg::SRC_W-1:0]   o_follower_time;
    logic [rcdt_pkg::ACT_W-1:0]   o_action;
    logic                         o_clamped;

    // predictor copies of the block's state and registers
    logic [rcdt_pkg::SRC_W-1:0]  follower_model = '0;
    logic [rcdt_pkg::CFG_W-1:0]  base_delay_q = rcdt_pkg::BASE_DELAY_RST;
    logic [rcdt_pkg::CFG_W-1:0]  drift_limit_q = rcdt_pkg::DRIFT_LIMIT_RST;
    logic [rcdt_pkg::FRAC_W-1:0] corr_frac_q = rcdt_pkg::CORR_FRAC_RST;

    t_frame_word   pending_frames[$];
    t_frame_result expected_frames[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int n_results = 0;
    int n_inits = 0;
    int n_corrects = 0;
    int n_snaps = 0;
    int n_clamps = 0;
    logic [63:0] session_src = '0;

    render_clock_drift_tracker_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_frame_delta   (in_delta),
        .i_source_time   (in_src),
        .i_speed_factor  (in_speed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_follower_time (o_follower_time),
        .o_action        (o_action),
        .o_clamped       (o_clamped)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // advance the follower by one frame and return what the block must report
    function automatic t_frame_result track_frame(
        input logic [rcdt_pkg::DELTA_W-1:0] delta,
        input logic [rcdt_pkg::SRC_W-1:0]   src,
        input logic [rcdt_pkg::SPEED_W-1:0] speed
    );
        logic [63:0] s, eff, delay, ideal, adv, limit, drift, corr, f;
        logic up;
        t_frame_result r;
        s = 64'(src);
        eff = (speed < rcdt_pkg::SPEED_ONE) ? 64'(rcdt_pkg::SPEED_ONE) : 64'(speed);
        delay = (64'(base_delay_q) * eff) >> rcdt_pkg::Q8_SHIFT;
        if (delay > TIME_MAX) delay = TIME_MAX;
        ideal = (s > delay) ? s - delay : 64'd0;
        r.clamped = 1'b0;
        if (follower_model == '0 && s != 0) begin
            f = ideal;
            r.action = rcdt_pkg::ACT_INIT;
        end else begin
            adv = (64'(delta) * 64'(speed)) >> rcdt_pkg::Q8_SHIFT;
            limit = (64'(drift_limit_q) * eff) >> rcdt_pkg::Q8_SHIFT;
            if (limit > TIME_MAX) limit = TIME_MAX;
            f = 64'(follower_model) + adv;
            if (f > TIME_MAX) f = TIME_MAX;
            up = (ideal >= f);
            drift = up ? ideal - f : f - ideal;
            if (drift > limit) begin
                f = ideal;
                r.action = rcdt_pkg::ACT_SNAP;
            end else begin
                // drift < 2^48 and fraction < 2^16, so the product fits
                corr = (drift * 64'(corr_frac_q)) >> rcdt_pkg::FRAC_SHIFT;
                f = up ? f + corr : f - corr;
                r.action = rcdt_pkg::ACT_CORRECT;
            end
            if (f > s) begin
                f = s;
                r.clamped = 1'b1;
            end
        end
        follower_model = f[rcdt_pkg::SRC_W-1:0];
        r.follower_time = f[rcdt_pkg::SRC_W-1:0];
        return r;
    endfunction

    // mostly a running source clock with plausible frame deltas, some noise
    function automatic t_frame_word next_frame();
        t_frame_word w;
        int unsigned pick;
        logic [63:0] step;
        logic [63:0] t;
        pick = $urandom_range(99);
        if (pick < 10) begin
            w.delta = $urandom();
            w.src = {16'($urandom_range(0, 65535)), $urandom()};
            w.speed = 16'($urandom_range(0, 65535));
            return w;
        end
        if (pick < 13) begin
            if ($urandom_range(1) == 0) begin
                // restart the session with the source parked at zero
                session_src = '0;
                w.delta = 32'($urandom_range(0, 2000000));
                w.src = '0;
                w.speed = 16'($urandom_range(0, 1024));
                return w;
            end
            session_src = {24'd0, 8'($urandom_range(0, 255)), $urandom()};
        end
        pick = $urandom_range(99);
        if (pick < 70)
            w.speed = 16'($urandom_range(256, 1024));
        else if (pick < 85)
            w.speed = 16'($urandom_range(0, 255));
        else
            w.speed = 16'($urandom_range(0, 65535));
        if ($urandom_range(99) < 85)
            w.delta = 32'($urandom_range(900000, 1300000));
        else
            w.delta = $urandom();
        step = (64'(w.delta) * 64'(w.speed)) >> rcdt_pkg::Q8_SHIFT;
        t = session_src + step + 64'($urandom_range(0, 2097152));
        t = (t >= 64'd1048576) ? t - 64'd1048576 : 64'd0;
        if (t > TIME_MAX) t = TIME_MAX;
        session_src = t;
        w.src = t[rcdt_pkg::SRC_W-1:0];
        return w;
    endfunction

    // driver: present pending words, predict each one as it is taken
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                expected_frames.push_back(track_frame(in_delta, in_src, in_speed));
            if (!in_valid || o_in_ready) begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_frame_word w;
                    w = pending_frames.pop_front();
                    in_valid <= 1'b1;
                    in_delta <= w.delta;
                    in_src <= w.src;
                    in_speed <= w.speed;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("result word with nothing pending: follower_time %0h", o_follower_time);
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    n_results++;
                    if (o_follower_time !== want.follower_time) begin
                        $error("follower_time: expected %0h, got %0h",
                               want.follower_time, o_follower_time);
                        fail_count++;
                    end
                    if (o_action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, o_action);
                        fail_count++;
                    end
                    if (o_clamped !== want.clamped) begin
                        $error("clamped: expected %0b, got %0b", want.clamped, o_clamped);
                        fail_count++;
                    end
                end
                case (o_action)
                    rcdt_pkg::ACT_INIT:    n_inits++;
                    rcdt_pkg::ACT_CORRECT: n_corrects++;
                    rcdt_pkg::ACT_SNAP:    n_snaps++;
                    default: ;
                endcase
                if (o_clamped === 1'b1) n_clamps++;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_frames.size() != 0 || in_valid || expected_frames.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [63:0] delta, input logic [63:0] src,
                              input logic [63:0] speed);
        @(negedge i_clk);
        pending_frames.push_back('{delta[rcdt_pkg::DELTA_W-1:0],
                                   src[rcdt_pkg::SRC_W-1:0],
                                   speed[rcdt_pkg::SPEED_W-1:0]});
        wait_drained();
    endtask

    task automatic write_reg(input logic [rcdt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcdt_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            rcdt_pkg::REG_BASE_DELAY:  base_delay_q = data;
            rcdt_pkg::REG_DRIFT_LIMIT: drift_limit_q = data;
            rcdt_pkg::REG_CORR_FRAC:   corr_frac_q = data[rcdt_pkg::FRAC_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int p);
        logic [rcdt_pkg::CFG_W-1:0] bd, dl, cf;
        case (p)
            0: begin bd = '0; dl = '0; cf = '0; end
            1: begin bd = '1; dl = '1; cf = 32'hFFFF; end
            2: begin
                bd = rcdt_pkg::BASE_DELAY_RST;
                dl = rcdt_pkg::DRIFT_LIMIT_RST;
                cf = 32'(rcdt_pkg::CORR_FRAC_RST);
            end
            4: begin bd = $urandom(); dl = $urandom(); cf = 32'($urandom_range(0, 65535)); end
            5: begin
                bd = rcdt_pkg::BASE_DELAY_RST;
                dl = $urandom_range(1000, 5000000);
                cf = 32'hFFFF;
            end
            6: begin bd = $urandom_range(0, 20000000); dl = '1; cf = '0; end
            default: begin
                bd = $urandom_range(0, 20000000);
                dl = $urandom_range(0, 100000000);
                cf = 32'($urandom_range(0, 65535));
            end
        endcase
        write_reg(rcdt_pkg::REG_BASE_DELAY, bd);
        write_reg(rcdt_pkg::REG_DRIFT_LIMIT, dl);
        write_reg(rcdt_pkg::REG_CORR_FRAC, cf);
    endtask

    initial begin : stimulus
        logic [63:0] f, d, l;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        d = 64'(rcdt_pkg::BASE_DELAY_RST);
        l = 64'(rcdt_pkg::DRIFT_LIMIT_RST);

        // directed frames, reset register values, no idling; each word drains first
        send_frame(1000, 0, 256);              // zero source from zero follower: clamp at 0
        send_frame(0, 1000, 256);              // initialise while the ideal is zero
        send_frame(1000000, 1000, 0);
        send_frame(1000000, 100000000, 256);   // ordinary initialisation
        send_frame(1092267, 101092267, 256);
        send_frame(0, 101092267, 0);           // no advance, speed below one
        f = 64'(follower_model);
        send_frame(1000000, f + d + 500000, 128);
        f = 64'(follower_model);
        send_frame(l, f + d, 256);             // drift exactly at the limit
        f = 64'(follower_model);
        send_frame(l + 1, f + d, 256);         // one past the limit: snap
        f = 64'(follower_model);
        send_frame(0, f + d + 1000000, 256);   // gradual move upwards
        f = 64'(follower_model);
        send_frame(32'hFFFF_FFFF, f, 16'hFFFF);
        send_frame(0, TIME_MAX, 16'hFFFF);
        send_frame(32'hFFFF_FFFF, TIME_MAX, 16'hFFFF);
        send_frame(5000, 5000, 256);           // ideal collapses to zero
        send_frame(0, 0, 0);
        send_frame(0, TIME_MAX, 300);          // initialise at the top of the range
        send_frame(1000000, TIME_MAX, 16'hFFFF);
        send_frame(1000, 0, 256);
        send_frame(1000, 2000, 512);

        for (int p = 0; p < SESSION_PHASES; p++) begin
            wait_drained();
            apply_setting(p);
            @(negedge i_clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            session_src = '0;
            for (int k = 0; k < FRAMES_PER_PHASE; k++)
                pending_frames.push_back(next_frame());
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("checked %0d result words across %0d register settings and four idling mixes",
                 n_results, SESSION_PHASES + 1);
        $display("actions seen: %0d initialise, %0d gradual, %0d snap; %0d clamped",
                 n_inits, n_corrects, n_snaps, n_clamps);
        if (fail_count == 0 && expected_frames.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* render_clock_drift_tracker_core.f */
hdl/rcdt_pkg.sv
hdl/rcdt_ctrl.sv
hdl/rcdt_datapath.sv
hdl/render_clock_drift_tracker_core.sv
hdl/rcdt_checker.sv
dv/tb_top.sv
